/* hdl/tape_pkg.sv */
// Package for the tilted-axis pointing error block.
// Types, constants and the CORDIC arctangent table; no dependencies.
`default_nettype none
package tape_pkg;

  localparam int unsigned Iters = 20;
  localparam int unsigned AngW = 32;              // internal angle, 2^-16 deg
  localparam int unsigned VecW = 34;              // Q30 vector values plus growth
  localparam int unsigned PrdW = 64;              // 32x32 signed product

  localparam logic signed [AngW-1:0] Deg      = 32'sd65536;
  localparam logic signed [AngW-1:0] QuarterT = 32'sd5898240;
  localparam logic signed [AngW-1:0] HalfT    = 32'sd11796480;
  localparam logic signed [AngW-1:0] FullT    = 32'sd23592960;
  localparam logic signed [VecW-1:0] KinvQ30  = 34'sd652032874;
  localparam logic signed [VecW-1:0] OneQ30   = 34'sd1073741824;

  function automatic logic signed [AngW-1:0] atan_tab(input logic [4:0] i);
    logic signed [AngW-1:0] v;
    case (i)
      5'd0:    v = 32'sd2949120;
      5'd1:    v = 32'sd1740967;
      5'd2:    v = 32'sd919879;
      5'd3:    v = 32'sd466945;
      5'd4:    v = 32'sd234379;
      5'd5:    v = 32'sd117304;
      5'd6:    v = 32'sd58666;
      5'd7:    v = 32'sd29335;
      5'd8:    v = 32'sd14668;
      5'd9:    v = 32'sd7334;
      5'd10:   v = 32'sd3667;
      5'd11:   v = 32'sd1833;
      5'd12:   v = 32'sd917;
      5'd13:   v = 32'sd458;
      5'd14:   v = 32'sd229;
      5'd15:   v = 32'sd115;
      5'd16:   v = 32'sd57;
      5'd17:   v = 32'sd29;
      5'd18:   v = 32'sd14;
      5'd19:   v = 32'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic signed [14:0] elevation;
    logic signed [16:0] azimuth;
  } tape_in_t;

  typedef struct packed {
    logic signed [15:0] azimuth_error;
    logic signed [15:0] elevation_error;
  } tape_out_t;

endpackage
`default_nettype wire

/* hdl/tape_in_if.sv */
// Valid/ready channel carrying one elevation/azimuth command.
// No dependencies.
`default_nettype none
interface tape_in_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] elevation;
  logic signed [16:0] azimuth;
  modport source (output valid, output elevation, output azimuth, input ready);
  modport sink   (input valid, input elevation, input azimuth, output ready);
endinterface
`default_nettype wire

/* hdl/tape_out_if.sv */
// Valid/ready channel carrying one pointing error result.
// No dependencies.
`default_nettype none
interface tape_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] azimuth_error;
  logic signed [15:0] elevation_error;
  modport source (output valid, output azimuth_error, output elevation_error, input ready);
  modport sink   (input valid, input azimuth_error, input elevation_error, output ready);
endinterface
`default_nettype wire

/* hdl/tape_sincos.sv */
// Pipelined CORDIC sine/cosine: one range-reduction stage, then one
// stage per rotation step. Depends on tape_pkg.
`default_nettype none
module tape_sincos (
  input  wire logic                            clk_i,
  input  wire logic                            en_i,
  input  wire logic signed [tape_pkg::AngW-1:0] ang_i,
  output logic signed [tape_pkg::VecW-1:0]      cos_o,
  output logic signed [tape_pkg::VecW-1:0]      sin_o
);
  import tape_pkg::*;

  logic signed [VecW-1:0] x_q [Iters+1];
  logic signed [VecW-1:0] y_q [Iters+1];
  logic signed [AngW:0]   z_q [Iters+1];
  logic                   n_q [Iters+1];

  logic signed [AngW:0] r0, r1;
  logic                 neg0;

  always_comb begin
    // angle reaches here already bounded to a few turns; reduce by compare
    r0 = {ang_i[AngW-1], ang_i};
    if (r0 >= $signed({1'b0, HalfT})) r0 = r0 - $signed({1'b0, FullT});
    if (r0 >= $signed({1'b0, HalfT})) r0 = r0 - $signed({1'b0, FullT});
    if (r0 < -$signed({1'b0, HalfT})) r0 = r0 + $signed({1'b0, FullT});
    if (r0 < -$signed({1'b0, HalfT})) r0 = r0 + $signed({1'b0, FullT});
    neg0 = 1'b0;
    r1 = r0;
    if (r0 > $signed({1'b0, QuarterT})) begin
      r1 = r0 - $signed({1'b0, HalfT});
      neg0 = 1'b1;
    end else if (r0 < -$signed({1'b0, QuarterT})) begin
      r1 = r0 + $signed({1'b0, HalfT});
      neg0 = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= KinvQ30;
      y_q[0] <= '0;
      z_q[0] <= r1;
      n_q[0] <= neg0;
    end
  end

  for (genvar i = 0; i < Iters; i++) begin : g_rot
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[i+1] <= n_q[i];
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - $signed({1'b0, atan_tab(5'(i))});
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + $signed({1'b0, atan_tab(5'(i))});
        end
      end
    end
  end

  assign cos_o = n_q[Iters] ? -x_q[Iters] : x_q[Iters];
  assign sin_o = n_q[Iters] ? -y_q[Iters] : y_q[Iters];
endmodule
`default_nettype wire

/* hdl/tape_atan2.sv */
// Pipelined CORDIC vectoring atan2 with quadrant pre-rotation.
// Depends on tape_pkg.
`default_nettype none
module tape_atan2 (
  input  wire logic                            clk_i,
  input  wire logic                            en_i,
  input  wire logic signed [tape_pkg::VecW-1:0] y_i,
  input  wire logic signed [tape_pkg::VecW-1:0] x_i,
  output logic signed [tape_pkg::AngW-1:0]      ang_o
);
  import tape_pkg::*;

  localparam int unsigned W = VecW + 2;

  logic signed [W-1:0]    x_q [Iters+1];
  logic signed [W-1:0]    y_q [Iters+1];
  logic signed [AngW-1:0] z_q [Iters+1];
  logic                   zero_q [Iters+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      if (x_i < 0) begin
        if (y_i >= 0) begin
          x_q[0] <= W'(y_i);
          y_q[0] <= -W'(x_i);
          z_q[0] <= QuarterT;
        end else begin
          x_q[0] <= -W'(y_i);
          y_q[0] <= W'(x_i);
          z_q[0] <= -QuarterT;
        end
      end else begin
        x_q[0] <= W'(x_i);
        y_q[0] <= W'(y_i);
        z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < Iters; i++) begin : g_vec
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        if (y_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + atan_tab(5'(i));
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - atan_tab(5'(i));
        end
      end
    end
  end

  assign ang_o = zero_q[Iters] ? '0 : z_q[Iters];
endmodule
`default_nettype wire

/* hdl/tape_acos.sv */
// Pipelined acos: clamp, square 1-z^2, one-bit-per-stage integer square
// root, then the atan2 pipeline. Depends on tape_pkg, tape_atan2.
`default_nettype none
module tape_acos (
  input  wire logic                            clk_i,
  input  wire logic                            en_i,
  input  wire logic signed [tape_pkg::VecW-1:0] z_i,
  output logic signed [tape_pkg::AngW-1:0]      ang_o
);
  import tape_pkg::*;

  localparam int unsigned NW = 61;   // 2^60 fits
  localparam int unsigned RW = 31;   // root up to 2^30
  localparam int unsigned Steps = 31;

  logic signed [VecW-1:0] zc_q;
  logic signed [VecW-1:0] zc1_q;
  logic [NW-1:0]          n0_q;
  logic [NW-1:0]          n_q  [Steps+1];
  logic [RW+1:0]          r_q  [Steps+1];
  logic signed [VecW-1:0] zp_q [Steps+1];
  logic signed [VecW-1:0] zc;
  logic [30:0]            zm;
  logic [61:0]            sq;

  always_comb begin
    zc = z_i;
    if (z_i > OneQ30) zc = OneQ30;
    if (z_i < -OneQ30) zc = -OneQ30;
  end

  // |zc| <= 2^30, square fits a 31x31 multiply
  always_comb begin
    zm = 31'(zc_q < 0 ? -zc_q : zc_q);
    sq = 62'(zm) * 62'(zm);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zc_q    <= zc;
      zc1_q   <= zc_q;
      n0_q    <= (NW'(1) << 60) - NW'(sq);
      n_q[0]  <= n0_q;
      r_q[0]  <= '0;
      zp_q[0] <= zc1_q;
    end
  end

  // restoring square root, result bit k per stage (MSB first)
  for (genvar s = 0; s < Steps; s++) begin : g_sqrt
    localparam int unsigned K = Steps - 1 - s;
    logic [NW+1:0] trial;
    assign trial = ({2'b0, NW'(r_q[s])} << (K + 1)) + ({2'b0, NW'(1)} << (2 * K));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zp_q[s+1] <= zp_q[s];
        if ({2'b0, n_q[s]} >= trial) begin
          n_q[s+1] <= n_q[s] - NW'(trial);
          r_q[s+1] <= r_q[s] | ((RW+2)'(1) << K);
        end else begin
          n_q[s+1] <= n_q[s];
          r_q[s+1] <= r_q[s];
        end
      end
    end
  end

  tape_atan2 u_atan2 (
    .clk_i (clk_i),
    .en_i  (en_i),
    .y_i   (VecW'(r_q[Steps])),
    .x_i   (zp_q[Steps]),
    .ang_o (ang_o)
  );
endmodule
`default_nettype wire

/* hdl/tilted_axis_pointing_error.sv */
// Tilted-axis pointing error: top level with handshake, datapath schedule
// and output conversion. Depends on tape_pkg, interfaces, tape_sincos,
// tape_atan2, tape_acos.
//
// Use: in_ch carries (elevation, azimuth) commands, out_ch returns one
// (azimuth_error, elevation_error) per command, in order. tilt_angle is
// written through cfg_we_i/cfg_wdata_i; the user must write it only while
// no command is in flight, which the block itself does not enforce.
// Throughput: one command per cycle unless out_ch stalls. Stages:
// 21 sin/cos CORDIC stages, 3 product stages, then the 55-stage acos path
// (clamp, square, 31 root stages, 21 atan2 stages; atan2 path
// delay-matched), then one conversion stage: 80 register stages in all.
// The whole pipeline advances on a single enable: when out_ch is full and
// the receiver holds ready low, everything freezes and nothing is lost.
// Reset clears the valid bits and sets tilt_angle to zero.
`default_nettype none
module tilted_axis_pointing_error #(
  parameter int unsigned ANGLE_FRAC_BITS = 7
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  tape_in_if.sink          in_ch,
  tape_out_if.source       out_ch,
  input  wire logic        cfg_we_i,
  input  wire logic [14:0] cfg_wdata_i
);
  import tape_pkg::*;

  localparam int unsigned Sh     = 16 - ANGLE_FRAC_BITS;
  localparam int unsigned SinLat = Iters + 1;
  localparam int unsigned AcosLat = 3 + 31 + Iters + 1;
  localparam int unsigned Lat    = SinLat + 3 + AcosLat + 1;
  localparam int unsigned AzDly  = AcosLat - (Iters + 1);
  localparam logic signed [AngW:0] Lim = (AngW+1)'(180) <<< ANGLE_FRAC_BITS;

  logic signed [14:0] tilt_q;
  logic [Lat-1:0]     vld_q;
  logic               en;

  assign en           = out_ch.ready || !out_ch.valid;
  assign in_ch.ready  = en;
  assign out_ch.valid = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tilt_q <= '0;
      vld_q  <= '0;
    end else begin
      if (cfg_we_i) tilt_q <= cfg_wdata_i;
      if (en) vld_q <= {vld_q[Lat-2:0], in_ch.valid};
    end
  end

  logic signed [VecW-1:0] ce, se, ca, sa, ct, st;

  tape_sincos u_sc_el (.clk_i, .en_i(en),
    .ang_i(AngW'($signed(in_ch.elevation)) <<< Sh), .cos_o(ce), .sin_o(se));
  tape_sincos u_sc_az (.clk_i, .en_i(en),
    .ang_i(AngW'($signed(in_ch.azimuth)) <<< Sh), .cos_o(ca), .sin_o(sa));
  tape_sincos u_sc_t (.clk_i, .en_i(en),
    .ang_i(AngW'($signed(tilt_q)) <<< Sh), .cos_o(ct), .sin_o(st));

  // products: stage 1 ce*sa, ce*ca, st*ca, st*sa, ct*se; stage 2 ct*(...)
  logic signed [VecW-1:0] cesa_q, ceca_q, stca_q, stsa_q, cz_q, ct1_q, se1_q;
  logic signed [VecW-1:0] cesa2_q, ceca2_q, stca2_q, stsa2_q, ctcs_q, ctcc_q, cz2_q, se2_q;
  logic signed [VecW-1:0] cx_q, cy_q, dx_q, dy_q, cz3_q, se3_q;

  // operands stay within +-2^31, so a 32x32 multiply holds the product
  function automatic logic signed [VecW-1:0] qmul(input logic signed [VecW-1:0] a,
                                                  input logic signed [VecW-1:0] b);
    logic signed [31:0]     a32;
    logic signed [31:0]     b32;
    logic signed [PrdW-1:0] p;
    a32 = 32'(a);
    b32 = 32'(b);
    p = PrdW'(a32) * PrdW'(b32);
    return VecW'(p >>> 30);
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      cesa_q <= qmul(ce, sa);
      ceca_q <= qmul(ce, ca);
      stca_q <= qmul(st, ca);
      stsa_q <= qmul(st, sa);
      cz_q   <= qmul(ct, se);
      ct1_q  <= ct;
      se1_q  <= se;
      ctcs_q  <= qmul(ct1_q, cesa_q);
      ctcc_q  <= qmul(ct1_q, ceca_q);
      cesa2_q <= cesa_q;
      ceca2_q <= ceca_q;
      stca2_q <= stca_q;
      stsa2_q <= stsa_q;
      cz2_q   <= cz_q;
      se2_q   <= se1_q;
      cx_q  <= stca2_q + ctcs_q;
      cy_q  <= ctcc_q - stsa2_q;
      dx_q  <= cesa2_q;
      dy_q  <= ceca2_q;
      cz3_q <= cz2_q;
      se3_q <= se2_q;
    end
  end

  logic signed [AngW-1:0] ad, ac, ed, ec;

  tape_atan2 u_at_d (.clk_i, .en_i(en), .y_i(dy_q), .x_i(dx_q), .ang_o(ad));
  tape_atan2 u_at_c (.clk_i, .en_i(en), .y_i(cy_q), .x_i(cx_q), .ang_o(ac));
  tape_acos  u_ac_d (.clk_i, .en_i(en), .z_i(se3_q), .ang_o(ed));
  tape_acos  u_ac_c (.clk_i, .en_i(en), .z_i(cz3_q), .ang_o(ec));

  // align the azimuth difference with the longer acos path
  logic signed [AngW:0] daz;
  logic signed [AngW:0] daz_q [AzDly];
  assign daz = $signed({ad[AngW-1], ad}) - $signed({ac[AngW-1], ac});
  always_ff @(posedge clk_i) begin
    if (en) begin
      daz_q[0] <= daz;
      for (int k = 1; k < AzDly; k++) daz_q[k] <= daz_q[k-1];
    end
  end

  function automatic logic signed [15:0] to_out(input logic signed [AngW:0] d);
    logic signed [AngW:0] w;
    logic signed [AngW:0] q;
    w = d;
    if (w > $signed({1'b0, HalfT})) w = w - $signed({1'b0, FullT});
    if (w < -$signed({1'b0, HalfT})) w = w + $signed({1'b0, FullT});
    q = (w + $signed((AngW+1)'(1) << (Sh - 1))) >>> Sh;
    if (q > Lim) q = Lim;
    if (q < -Lim) q = -Lim;
    if (q > 33'sd32767) q = 33'sd32767;
    if (q < -33'sd32767) q = -33'sd32767;
    return q[15:0];
  endfunction

  logic signed [15:0] aze_q, ele_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      aze_q <= to_out(daz_q[AzDly-1]);
      ele_q <= to_out($signed({ed[AngW-1], ed}) - $signed({ec[AngW-1], ec}));
    end
  end

  assign out_ch.azimuth_error   = aze_q;
  assign out_ch.elevation_error = ele_q;
endmodule
`default_nettype wire

/* dv/tape_tb_if.sv */
// Testbench-side copies are not needed; the RTL interfaces tape_in_if and
// tape_out_if are used directly. This file holds the stimulus item type.
// Depends on tape_pkg.
`default_nettype none
package tape_tb_pkg;
  import tape_pkg::*;

  typedef struct {
    tape_in_t cmd;
    int unsigned gap;
  } cmd_item_t;
endpackage
`default_nettype wire

/* dv/tilted_axis_pointing_error_tb.sv */
// Testbench for tilted_axis_pointing_error: random and directed commands,
// bit-exact CORDIC predictor, in-order result checking.
// Depends on tape_pkg, tape_tb_pkg, tape_in_if, tape_out_if and the RTL.
`default_nettype none
module tilted_axis_pointing_error_tb;
  import tape_pkg::*;
  import tape_tb_pkg::*;

  localparam int FracBits = 7;
  localparam int PipeLat = 80;
  localparam int WatchLimit = 5000;

  localparam longint TurnDeg = 65536;
  localparam longint Quarter = 90 * TurnDeg;
  localparam longint Half = 180 * TurnDeg;
  localparam longint Full = 360 * TurnDeg;
  localparam longint OneQ = longint'(1) << 30;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [14:0] cfg_wdata_i = '0;

  tape_in_if in_ch ();
  tape_out_if out_ch ();

  tilted_axis_pointing_error #(.ANGLE_FRAC_BITS(FracBits)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  cmd_item_t pending_cmds[$];
  tape_out_t expected_errors[$];
  logic signed [14:0] tilt_q = '0;
  int fail_count = 0;
  int idle_cycles = 0;
  bit hold_rx = 1'b0;
  int hold_left = 0;
  int send_wait = 0;
  int recv_wait = 0;
  bit send_busy = 1'b0;
  bit in_acc = 1'b0;

  // ---------------- predictor ----------------
  function automatic longint atan_step(int i);
    return longint'(atan_tab(5'(i)));
  endfunction

  function automatic void cordic_sincos(input longint a, output longint c,
                                        output longint s);
    longint r, x, y, z, nx;
    bit neg;
    r = a % Full;
    x = KinvQ30;
    y = 0;
    neg = 1'b0;
    if (r < 0) r += Full;
    if (r >= Half) r -= Full;
    if (r > Quarter) begin
      r -= Half; neg = 1'b1;
    end else if (r < -Quarter) begin
      r += Half; neg = 1'b1;
    end
    z = r;
    for (int i = 0; i < 20; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= atan_step(i);
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += atan_step(i);
      end
      x = nx;
    end
    if (neg) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endfunction

  function automatic longint vec_angle(longint y, longint x);
    longint z, t, nx;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = Quarter;
      end else begin
        t = x; x = -y; y = t; z = -Quarter;
      end
    end
    for (int i = 0; i < 20; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i); y = y - (x >>> i); z += atan_step(i);
      end else begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= atan_step(i);
      end
      x = nx;
    end
    return z;
  endfunction

  function automatic longint floor_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = longint'(1) << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b; res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint zenith_angle(longint z);
    if (z > OneQ) z = OneQ;
    if (z < -OneQ) z = -OneQ;
    return vec_angle(floor_sqrt(longint'(OneQ * OneQ - z * z)), z);
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    return (a * b) >>> 30;
  endfunction

  function automatic logic signed [15:0] wrap_round(longint d);
    longint q, lim;
    lim = longint'(180) << FracBits;
    if (d > Half) d -= Full;
    if (d < -Half) d += Full;
    q = (d + (longint'(1) << (15 - FracBits))) >>> (16 - FracBits);
    if (q > lim) q = lim;
    if (q < -lim) q = -lim;
    if (q > 32767) q = 32767;
    if (q < -32767) q = -32767;
    return 16'(q);
  endfunction

  function automatic tape_out_t pointing_error(tape_in_t c, logic signed [14:0] tilt);
    longint sc, ce, se, ca, sa, ct, st, ce_sa, ce_ca, cx, cy, cz;
    tape_out_t r;
    sc = longint'(1) << (16 - FracBits);
    cordic_sincos(longint'(c.elevation) * sc, ce, se);
    cordic_sincos(longint'(c.azimuth) * sc, ca, sa);
    cordic_sincos(longint'(tilt) * sc, ct, st);
    ce_sa = q30_mul(ce, sa);
    ce_ca = q30_mul(ce, ca);
    cx = q30_mul(st, ca) + q30_mul(ct, ce_sa);
    cy = -q30_mul(st, sa) + q30_mul(ct, ce_ca);
    cz = q30_mul(ct, se);
    r.azimuth_error = wrap_round(vec_angle(ce_ca, ce_sa) - vec_angle(cy, cx));
    r.elevation_error = wrap_round(zenith_angle(se) - zenith_angle(cz));
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  // ---------------- driver ----------------
  initial begin
    in_ch.valid = 1'b0;
    in_ch.elevation = '0;
    in_ch.azimuth = '0;
  end

  // input acceptance as seen at the rising edge
  always @(posedge clk_i) begin
    in_acc <= rst_ni && in_ch.valid && in_ch.ready;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_acc) begin
        send_busy = 1'b0;
      end
      if (!send_busy) begin
        if (send_wait > 0) begin
          send_wait--;
          in_ch.valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cmd_item_t it;
          it = pending_cmds.pop_front();
          send_wait = it.gap;
          in_ch.elevation <= it.cmd.elevation;
          in_ch.azimuth <= it.cmd.azimuth;
          in_ch.valid <= 1'b1;
          send_busy = 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with an optional long hold-off
  initial out_ch.ready = 1'b0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_rx) begin
        hold_rx = 1'b0;
        hold_left = 300;
        out_ch.ready <= 1'b0;
      end else if (out_ch.valid && out_ch.ready) begin
        recv_wait = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) recv_wait = 0;
        out_ch.ready <= (recv_wait == 0);
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_ch.ready <= (recv_wait == 0);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk_i) begin
    bit act;
    act = 1'b0;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        tape_in_t c;
        c.elevation = in_ch.elevation;
        c.azimuth = in_ch.azimuth;
        expected_errors.push_back(pointing_error(c, tilt_q));
        act = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        act = 1'b1;
        if (expected_errors.size() == 0) begin
          report_mismatch("unexpected transaction", out_ch.azimuth_error, 0);
        end else begin
          tape_out_t e;
          e = expected_errors.pop_front();
          if (out_ch.azimuth_error !== e.azimuth_error)
            report_mismatch("azimuth_error", out_ch.azimuth_error, e.azimuth_error);
          if (out_ch.elevation_error !== e.elevation_error)
            report_mismatch("elevation_error", out_ch.elevation_error,
                            e.elevation_error);
        end
      end
      idle_cycles <= act ? 0 : idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ---------------- stimulus ----------------
  function automatic cmd_item_t make_cmd(int el, int az, bit zero_gap);
    cmd_item_t it;
    it.cmd.elevation = 15'(el);
    it.cmd.azimuth = 17'(az);
    it.gap = zero_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5));
    return it;
  endfunction

  task automatic drain_all();
    while (pending_cmds.size() > 0 || send_busy || expected_errors.size() > 0)
      @(posedge clk_i);
    repeat (PipeLat + 5) @(posedge clk_i);
  endtask

  task automatic write_tilt(logic signed [14:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    tilt_q = v;
  endtask

  task automatic random_block(int n, bit raw_bits);
    int el, az;
    for (int i = 0; i < n; i++) begin
      if (raw_bits) begin
        el = $urandom;
        az = $urandom;
      end else begin
        el = $urandom_range(0, 23040) - 11520;
        az = $urandom_range(0, 92160) - 46080;
      end
      pending_cmds.push_back(make_cmd(el, az, 1'b0));
    end
  endtask

  initial begin
    int tilts[6];
    tilts = '{0, 11520, -11520, 640, -2879, 16383};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, coincident direction (zenith), zero tilt
    write_tilt(15'sd0);
    foreach (tilts[k]) begin
      if (k > 0) write_tilt(15'(tilts[k]));
      if (k < 2) begin
        pending_cmds.push_back(make_cmd(0, 0, 1'b0));
        pending_cmds.push_back(make_cmd(11520, 0, 1'b0));
        pending_cmds.push_back(make_cmd(-11520, 46080, 1'b0));
        pending_cmds.push_back(make_cmd(11520, -46080, 1'b0));
        pending_cmds.push_back(make_cmd(-16384, -65536, 1'b0));
        pending_cmds.push_back(make_cmd(16383, 65535, 1'b0));
        pending_cmds.push_back(make_cmd(5760, 23040, 1'b0));
        pending_cmds.push_back(make_cmd(-5760, -23040, 1'b0));
        pending_cmds.push_back(make_cmd(0, 11520, 1'b0));
        pending_cmds.push_back(make_cmd(128, -128, 1'b0));
      end
      if (k == 2) begin
        // back-to-back items while the receiver stalls, to fill the pipe
        hold_rx = 1'b1;
        for (int i = 0; i < 90; i++)
          pending_cmds.push_back(make_cmd($urandom_range(0, 23040) - 11520,
                                          $urandom_range(0, 92160) - 46080, 1'b1));
      end else begin
        random_block(50, 1'b0);
        random_block(10, 1'b1);
      end
      drain_all();
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
